### rtl/logic_capture_signal_analyzer_unit_defines.svh
// Assertion macros shared by the checker of the signal analyzer.
`ifndef LOGIC_CAPTURE_SIGNAL_ANALYZER_UNIT_DEFINES_SVH
`define LOGIC_CAPTURE_SIGNAL_ANALYZER_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define LCSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LCSA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/lcsa_pkg.sv
package lcsa_pkg;

  // Word and lane geometry.
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_SHIFT = $clog2(WORD_W);
  localparam int unsigned LANE_W     = 8;
  localparam int unsigned NUM_LANES  = WORD_W / LANE_W;
  localparam int unsigned LANE_CNT_W = $clog2(LANE_W + 1);
  localparam int unsigned WORD_CNT_W = $clog2(WORD_W + 1);
  localparam int unsigned INC_W      = WORD_CNT_W + 1;

  // Capture limits and fixed point format.
  localparam int unsigned MAX_WORDS  = 65536;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned SAMPLE_W   = 22;
  localparam int unsigned EDGE_W     = 21;
  localparam int unsigned WORDS_W    = 17;
  localparam int unsigned RATE_W     = 28;
  localparam int unsigned DUTY_W     = 15;
  localparam int unsigned FREQ_W     = 35;
  localparam int unsigned AVG_W      = 30;
  localparam int unsigned CLASS_W    = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_CAP = SAMPLE_W'(MAX_WORDS * WORD_W);
  localparam logic [SAMPLE_W-1:0] EDGE_CAP   = SAMPLE_W'(MAX_WORDS * WORD_W - 1);
  localparam logic [SAMPLE_W-1:0] WORDS_CAP  = SAMPLE_W'(MAX_WORDS);
  localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(1000000);

  // Division operands. The factor 32 of the sample total is folded into
  // the numerator scale, so every divisor is a raw count.
  localparam int unsigned DUTY_SCALE  = (100 * (1 << FRAC_BITS)) / WORD_W;
  localparam int unsigned DUTY_NUM_W  = 31;
  localparam int unsigned FREQ_SHIFT  = FRAC_BITS - 1 - WORD_SHIFT;
  localparam int unsigned PROD_W      = EDGE_W + RATE_W;
  localparam int unsigned FREQ_NUM_W  = PROD_W + FREQ_SHIFT;
  localparam int unsigned AVG_NUM_W   = SAMPLE_W + FRAC_BITS;

  typedef struct packed {
    logic [LANE_CNT_W-1:0] ones;
    logic [LANE_CNT_W-1:0] rises;
    logic [LANE_CNT_W-1:0] falls;
  } lane_cnt_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high;
    logic [SAMPLE_W-1:0] low;
    logic [EDGE_W-1:0]   edges;
    logic [WORDS_W-1:0]  words;
    logic [SAMPLE_W-1:0] hpulse;
    logic [SAMPLE_W-1:0] lpulse;
  } capture_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_CONSTANT = 2'd0,
    CLS_SQUARE   = 2'd1,
    CLS_PERIODIC = 2'd2,
    CLS_UNKNOWN  = 2'd3
  } signal_class_e;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MUL,
    ST_START,
    ST_DIV
  } state_e;

  // Saturating add of a small increment to a counter.
  function automatic logic [SAMPLE_W-1:0] sat_add(input logic [SAMPLE_W-1:0] v,
                                                  input logic [INC_W-1:0]    inc,
                                                  input logic [SAMPLE_W-1:0] cap);
    logic [SAMPLE_W:0] sum;
    sum = {1'b0, v} + (SAMPLE_W + 1)'(inc);
    return (sum > {1'b0, cap}) ? cap : sum[SAMPLE_W-1:0];
  endfunction

endpackage

### rtl/logic_capture_signal_analyzer_unit.sv
// Logic capture signal analyzer.
// Input channel: in_valid_i/in_ready_o carry one word of 32 one-bit samples
// (bit 0 earliest) and a flag that marks the last word of a capture.
// Output channel: out_valid_o/out_ready_i carry one result per capture.
// Write the sample rate register with cfg_we_i/cfg_wdata_i only while idle;
// the block itself does not enforce this. Inside a capture one word is taken
// every cycle: four 8-bit lanes count high samples and level changes, and
// a merge stage adds them into saturating totals. After the last word the
// input stalls while four bit-serial dividers work; the 51-bit frequency
// quotient sets the length. The next capture may start in the cycle in
// which the result appears, even while the result is still held.
// A receiver stall holds the result in the output register; a further
// capture then waits at its end until the result has been taken.
// Reset clears the running counts, drops out_valid_o and sets the sample
// rate to 1000000 Hz. There is no clearing pass after reset.
module logic_capture_signal_analyzer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcsa_pkg::RATE_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lcsa_pkg::WORD_W-1:0]   sample_word_i,
  input  logic                          last_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcsa_pkg::SAMPLE_W-1:0] high_samples_o,
  output logic [lcsa_pkg::SAMPLE_W-1:0] low_samples_o,
  output logic [lcsa_pkg::EDGE_W-1:0]   edge_count_o,
  output logic [lcsa_pkg::SAMPLE_W-1:0] sample_total_o,
  output logic [lcsa_pkg::WORDS_W-1:0]  words_seen_o,
  output logic [lcsa_pkg::DUTY_W-1:0]   duty_percent_q8_o,
  output logic [lcsa_pkg::FREQ_W-1:0]   freq_hz_q8_o,
  output logic [lcsa_pkg::AVG_W-1:0]    avg_high_pulse_q8_o,
  output logic [lcsa_pkg::AVG_W-1:0]    avg_low_pulse_q8_o,
  output logic [lcsa_pkg::CLASS_W-1:0]  signal_class_o
);

  lcsa_pkg::state_e                     state_q, state_d;
  logic [lcsa_pkg::RATE_W-1:0]          rate_q;
  logic                                 in_acc;
  logic                                 div_start;
  logic                                 out_load;
  logic                                 out_valid_q;
  lcsa_pkg::capture_t                   fin, f_q;
  logic [lcsa_pkg::PROD_W-1:0]          prod_q;
  logic [lcsa_pkg::DUTY_NUM_W-1:0]      duty_num, duty_quo;
  logic [lcsa_pkg::FREQ_NUM_W-1:0]      freq_num, freq_quo;
  logic [lcsa_pkg::AVG_NUM_W-1:0]       hi_num, lo_num, hi_quo, lo_quo;
  logic                                 duty_busy, freq_busy, hi_busy, lo_busy;
  logic [lcsa_pkg::SAMPLE_W-1:0]        total, total_half;
  lcsa_pkg::signal_class_e              cls;

  assign in_acc = in_valid_i && in_ready_o;

  // Sample rate register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= lcsa_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  lcsa_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_acc_i    (in_acc),
    .sample_word_i (sample_word_i),
    .last_word_i   (last_word_i),
    .fin_o         (fin)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcsa_pkg::ST_ACC: begin
        if (in_acc && last_word_i) begin
          state_d = lcsa_pkg::ST_MUL;
        end
      end
      lcsa_pkg::ST_MUL:   state_d = lcsa_pkg::ST_START;
      lcsa_pkg::ST_START: state_d = lcsa_pkg::ST_DIV;
      lcsa_pkg::ST_DIV: begin
        if (out_load) begin
          state_d = lcsa_pkg::ST_ACC;
        end
      end
      default: state_d = lcsa_pkg::ST_ACC;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      lcsa_pkg::ST_ACC:   in_ready_o = 1'b1;
      lcsa_pkg::ST_START: div_start  = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcsa_pkg::ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  // Final totals of the capture and the edge-rate product.
  always_ff @(posedge clk_i) begin
    if (in_acc && last_word_i) begin
      f_q <= fin;
    end
    if (state_q == lcsa_pkg::ST_MUL) begin
      prod_q <= lcsa_pkg::PROD_W'(f_q.edges) * lcsa_pkg::PROD_W'(rate_q);
    end
  end

  // Divider operands.
  assign duty_num = lcsa_pkg::DUTY_NUM_W'(f_q.high) *
                    lcsa_pkg::DUTY_NUM_W'(lcsa_pkg::DUTY_SCALE);
  assign freq_num = lcsa_pkg::FREQ_NUM_W'(prod_q) << lcsa_pkg::FREQ_SHIFT;
  assign hi_num   = lcsa_pkg::AVG_NUM_W'(f_q.high) << lcsa_pkg::FRAC_BITS;
  assign lo_num   = lcsa_pkg::AVG_NUM_W'(f_q.low) << lcsa_pkg::FRAC_BITS;

  lcsa_div #(.NumW(lcsa_pkg::DUTY_NUM_W), .DenW(lcsa_pkg::WORDS_W)) u_div_duty (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (duty_num), .den_i (f_q.words), .busy_o (duty_busy), .quot_o (duty_quo)
  );

  lcsa_div #(.NumW(lcsa_pkg::FREQ_NUM_W), .DenW(lcsa_pkg::WORDS_W)) u_div_freq (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (freq_num), .den_i (f_q.words), .busy_o (freq_busy), .quot_o (freq_quo)
  );

  lcsa_div #(.NumW(lcsa_pkg::AVG_NUM_W), .DenW(lcsa_pkg::SAMPLE_W)) u_div_hi (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (hi_num), .den_i (f_q.hpulse), .busy_o (hi_busy), .quot_o (hi_quo)
  );

  lcsa_div #(.NumW(lcsa_pkg::AVG_NUM_W), .DenW(lcsa_pkg::SAMPLE_W)) u_div_lo (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start),
    .num_i (lo_num), .den_i (f_q.lpulse), .busy_o (lo_busy), .quot_o (lo_quo)
  );

  // Signal class from the edge count and the balance of levels.
  assign total      = lcsa_pkg::SAMPLE_W'(f_q.words) << lcsa_pkg::WORD_SHIFT;
  assign total_half = lcsa_pkg::SAMPLE_W'(f_q.words) << (lcsa_pkg::WORD_SHIFT - 1);

  always_comb begin
    if (f_q.edges == '0) begin
      cls = lcsa_pkg::CLS_CONSTANT;
    end else if (f_q.edges == lcsa_pkg::EDGE_W'(2) && f_q.high == total_half) begin
      cls = lcsa_pkg::CLS_SQUARE;
    end else if (f_q.edges >= lcsa_pkg::EDGE_W'(4)) begin
      cls = lcsa_pkg::CLS_PERIODIC;
    end else begin
      cls = lcsa_pkg::CLS_UNKNOWN;
    end
  end

  // The result moves to the output register once the dividers are done and the slot is free.
  assign out_load = (state_q == lcsa_pkg::ST_DIV) &&
                    !(duty_busy || freq_busy || hi_busy || lo_busy) &&
                    (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      high_samples_o      <= f_q.high;
      low_samples_o       <= f_q.low;
      edge_count_o        <= f_q.edges;
      sample_total_o      <= total;
      words_seen_o        <= f_q.words;
      duty_percent_q8_o   <= duty_quo[lcsa_pkg::DUTY_W-1:0];
      freq_hz_q8_o        <= (f_q.edges > lcsa_pkg::EDGE_W'(1)) ?
                             freq_quo[lcsa_pkg::FREQ_W-1:0] : '0;
      avg_high_pulse_q8_o <= (f_q.hpulse != '0) ? hi_quo[lcsa_pkg::AVG_W-1:0] : '0;
      avg_low_pulse_q8_o  <= (f_q.lpulse != '0) ? lo_quo[lcsa_pkg::AVG_W-1:0] : '0;
      signal_class_o      <= cls;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/lcsa_lane.sv
module lcsa_lane (
  input  logic                        prev_i,
  input  logic [lcsa_pkg::LANE_W-1:0] bits_i,
  output lcsa_pkg::lane_cnt_t         cnt_o
);

  logic [lcsa_pkg::LANE_W:0] seq;

  // The sample just before this lane sits below the lane's own samples.
  assign seq = {bits_i, prev_i};

  // Count high samples and both kinds of level change inside the lane.
  always_comb begin
    cnt_o = '0;
    for (int i = 0; i < lcsa_pkg::LANE_W; i++) begin
      cnt_o.ones  = cnt_o.ones  + lcsa_pkg::LANE_CNT_W'(seq[i+1]);
      cnt_o.rises = cnt_o.rises + lcsa_pkg::LANE_CNT_W'(!seq[i] && seq[i+1]);
      cnt_o.falls = cnt_o.falls + lcsa_pkg::LANE_CNT_W'(seq[i] && !seq[i+1]);
    end
  end

endmodule

### rtl/lcsa_div.sv
module lcsa_div #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  // One restoring step: bring down the next numerator bit and subtract.
  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    if (trial >= {1'b0, den_q}) begin
      rem_d = diff[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], 1'b1};
    end else begin
      rem_d = trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], 1'b0};
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Numerator shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

### rtl/lcsa_merge.sv
module lcsa_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        word_acc_i,
  input  logic [lcsa_pkg::WORD_W-1:0] sample_word_i,
  input  logic                        last_word_i,
  output lcsa_pkg::capture_t          fin_o
);

  lcsa_pkg::capture_t                   acc_q, acc_d;
  logic                                 prev_q;
  logic                                 first_q;
  logic [lcsa_pkg::NUM_LANES-1:0]       lane_prev;
  lcsa_pkg::lane_cnt_t                  lane_cnt [lcsa_pkg::NUM_LANES];
  logic [lcsa_pkg::WORD_CNT_W-1:0]      ones_sum, rise_sum, fall_sum;
  logic [lcsa_pkg::INC_W-1:0]           low_inc, edge_inc, hp_inc, lp_inc;
  logic                                 last_lvl;

  // The first word of a capture starts at its own bit 0, so no edge there.
  assign lane_prev[0] = first_q ? sample_word_i[0] : prev_q;

  for (genvar k = 1; k < lcsa_pkg::NUM_LANES; k++) begin : g_prev
    assign lane_prev[k] = sample_word_i[k*lcsa_pkg::LANE_W-1];
  end

  for (genvar k = 0; k < lcsa_pkg::NUM_LANES; k++) begin : g_lane
    lcsa_lane u_lane (
      .prev_i (lane_prev[k]),
      .bits_i (sample_word_i[k*lcsa_pkg::LANE_W +: lcsa_pkg::LANE_W]),
      .cnt_o  (lane_cnt[k])
    );
  end

  // Merge the lane counts of one word.
  always_comb begin
    ones_sum = '0;
    rise_sum = '0;
    fall_sum = '0;
    for (int k = 0; k < lcsa_pkg::NUM_LANES; k++) begin
      ones_sum = ones_sum + lcsa_pkg::WORD_CNT_W'(lane_cnt[k].ones);
      rise_sum = rise_sum + lcsa_pkg::WORD_CNT_W'(lane_cnt[k].rises);
      fall_sum = fall_sum + lcsa_pkg::WORD_CNT_W'(lane_cnt[k].falls);
    end
  end

  // On the last word the pulse still open is closed at the final level.
  assign last_lvl = sample_word_i[lcsa_pkg::WORD_W-1];
  assign low_inc  = lcsa_pkg::INC_W'(lcsa_pkg::WORD_W) - lcsa_pkg::INC_W'(ones_sum);
  assign edge_inc = lcsa_pkg::INC_W'(rise_sum) + lcsa_pkg::INC_W'(fall_sum);
  assign hp_inc   = lcsa_pkg::INC_W'(fall_sum) + lcsa_pkg::INC_W'(last_word_i && last_lvl);
  assign lp_inc   = lcsa_pkg::INC_W'(rise_sum) + lcsa_pkg::INC_W'(last_word_i && !last_lvl);

  // Saturating totals after this word.
  always_comb begin
    acc_d.high   = lcsa_pkg::sat_add(acc_q.high, lcsa_pkg::INC_W'(ones_sum),
                                     lcsa_pkg::SAMPLE_CAP);
    acc_d.low    = lcsa_pkg::sat_add(acc_q.low, low_inc, lcsa_pkg::SAMPLE_CAP);
    acc_d.edges  = lcsa_pkg::EDGE_W'(lcsa_pkg::sat_add(
                     lcsa_pkg::SAMPLE_W'(acc_q.edges), edge_inc, lcsa_pkg::EDGE_CAP));
    acc_d.words  = lcsa_pkg::WORDS_W'(lcsa_pkg::sat_add(
                     lcsa_pkg::SAMPLE_W'(acc_q.words), lcsa_pkg::INC_W'(1),
                     lcsa_pkg::WORDS_CAP));
    acc_d.hpulse = lcsa_pkg::sat_add(acc_q.hpulse, hp_inc, lcsa_pkg::SAMPLE_CAP);
    acc_d.lpulse = lcsa_pkg::sat_add(acc_q.lpulse, lp_inc, lcsa_pkg::SAMPLE_CAP);
  end

  assign fin_o = acc_d;

  // Accumulators restart after the last word of a capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      prev_q  <= 1'b0;
      first_q <= 1'b1;
    end else if (word_acc_i) begin
      if (last_word_i) begin
        acc_q   <= '0;
        prev_q  <= 1'b0;
        first_q <= 1'b1;
      end else begin
        acc_q   <= acc_d;
        prev_q  <= last_lvl;
        first_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/lcsa_checker.sv
`include "logic_capture_signal_analyzer_unit_defines.svh"

module lcsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_word_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [lcsa_pkg::SAMPLE_W-1:0] high_samples_o,
  input logic [lcsa_pkg::SAMPLE_W-1:0] sample_total_o,
  input logic [lcsa_pkg::WORDS_W-1:0]  words_seen_o,
  input logic [lcsa_pkg::EDGE_W-1:0]   edge_count_o,
  input logic [lcsa_pkg::FREQ_W-1:0]   freq_hz_q8_o,
  input logic [lcsa_pkg::CLASS_W-1:0]  signal_class_o
);

  // A stalled result stays on the port unchanged.
  `LCSA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(high_samples_o) && $stable(sample_total_o), "result changed while stalled")

  // Right after the last word of a capture is taken, the input is blocked.
  `LCSA_ASSERT(a_end_stall, in_valid_i && in_ready_o && last_word_i |=> !in_ready_o, "word taken right after the last word")

  // The sample total is 32 samples per word seen and bounds the high count.
  `LCSA_ASSERT(a_total, out_valid_o |-> sample_total_o[lcsa_pkg::WORD_SHIFT-1:0] == '0 && sample_total_o[lcsa_pkg::SAMPLE_W-1:lcsa_pkg::WORD_SHIFT] == words_seen_o[lcsa_pkg::SAMPLE_W-lcsa_pkg::WORD_SHIFT-1:0] && high_samples_o <= sample_total_o, "inconsistent sample totals")

  // A constant signal has no edges and no frequency.
  `LCSA_ASSERT(a_constant, out_valid_o && signal_class_o == lcsa_pkg::CLS_CONSTANT |-> edge_count_o == '0 && freq_hz_q8_o == '0, "constant class with edges")

  // No result is shown during reset.
  `LCSA_ASSERT_ALWAYS(a_reset, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind logic_capture_signal_analyzer_unit lcsa_checker u_lcsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_word_i    (last_word_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .high_samples_o (high_samples_o),
  .sample_total_o (sample_total_o),
  .words_seen_o   (words_seen_o),
  .edge_count_o   (edge_count_o),
  .freq_hz_q8_o   (freq_hz_q8_o),
  .signal_class_o (signal_class_o)
);
